>>> rtl/iap_pkg.sv
// Shared types and constants for the IEC 104 APDU object parser.
// No dependencies; used by iap_layout and the top level.
package iap_pkg;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  localparam logic [7:0] START_BYTE = 8'h68;
  localparam logic [3:0] NONE_OFF   = 4'hF;

  typedef struct packed {
    logic [3:0] stride;
    logic [2:0] vlen;
    logic [3:0] qoff;
    logic [3:0] toff;
  } layout_t;

  typedef struct packed {
    logic [7:0]  type_id;
    logic [23:0] object_address;
    logic [15:0] common_address;
    logic [31:0] value_bits;
    logic [7:0]  quality_bits;
    logic [55:0] time_raw;
    logic        has_time;
    logic [14:0] next_rx_seq;
    logic        last_of_frame;
  } result_t;

endpackage

>>> rtl/iap_layout.sv
// Object layout lookup by ASDU type.
// Depends on iap_pkg.
module iap_layout (
  input  logic [7:0]      type_id,
  output iap_pkg::layout_t layout
);

  // Map type to stride, value length, quality and time offsets
  always_comb begin
    case (type_id)
      8'd1, 8'd3:                 layout = '{4'd1, 3'd1, 4'd0, iap_pkg::NONE_OFF};
      8'd5:                       layout = '{4'd2, 3'd1, 4'd1, iap_pkg::NONE_OFF};
      8'd7, 8'd13, 8'd15, 8'd20:  layout = '{4'd5, 3'd4, 4'd4, iap_pkg::NONE_OFF};
      8'd9, 8'd11:                layout = '{4'd3, 3'd2, 4'd2, iap_pkg::NONE_OFF};
      8'd21:                      layout = '{4'd2, 3'd2, iap_pkg::NONE_OFF,
                                             iap_pkg::NONE_OFF};
      8'd30, 8'd31:               layout = '{4'd8, 3'd1, 4'd0, 4'd1};
      8'd32:                      layout = '{4'd9, 3'd1, 4'd1, 4'd2};
      8'd33, 8'd36, 8'd37:        layout = '{4'd12, 3'd4, 4'd4, 4'd5};
      8'd34, 8'd35:               layout = '{4'd10, 3'd2, 4'd2, 4'd3};
      8'd38, 8'd39, 8'd40:        layout = '{4'd11, 3'd1, 4'd1, 4'd4};
      default:                    layout = '{4'd0, 3'd0, iap_pkg::NONE_OFF,
                                             iap_pkg::NONE_OFF};
    endcase
  end

endmodule

>>> rtl/iec104_apdu_object_parser.sv
// IEC 104 APDU parser: one byte per cycle in, one object result out.
// Latency: a result appears on the output register the cycle after the
// transfer of the object's last byte. Throughput: one byte every cycle;
// input stalls in any cycle where a result is held and out_ready is low.
// Reset: synchronous, rst high, clears all parse state and returns to
// start-byte hunting.
module iec104_apdu_object_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  type_id,
  output logic [23:0] object_address,
  output logic [15:0] common_address,
  output logic [31:0] value_bits,
  output logic [7:0]  quality_bits,
  output logic [55:0] time_raw,
  output logic        has_time,
  output logic [14:0] next_rx_seq,
  output logic        last_of_frame
);

  iap_pkg::phase_t parse_phase, parse_phase_next;
  logic [7:0]  frame_length, byte_position;
  logic        frame_is_info, sequence_mode;
  logic [7:0]  object_type;
  logic [6:0]  object_count, object_index;
  logic [15:0] asdu_address;
  logic [23:0] running_address;
  logic [3:0]  element_byte;
  logic [31:0] value_accum;
  logic [7:0]  quality_hold;
  logic [55:0] time_accum;
  logic [14:0] send_seq_next;

  logic [7:0]  frame_length_next, byte_position_next, object_type_next;
  logic        frame_is_info_next, sequence_mode_next;
  logic [6:0]  object_count_next, object_index_next;
  logic [15:0] asdu_address_next;
  logic [23:0] running_address_next;
  logic [3:0]  element_byte_next;
  logic [31:0] value_accum_next;
  logic [7:0]  quality_hold_next;
  logic [55:0] time_accum_next;
  logic [14:0] send_seq_next_next;

  iap_pkg::layout_t ly;
  iap_pkg::result_t res, res_q;
  logic             emit;
  logic             accept;

  iap_layout u_layout (.type_id(object_type), .layout(ly));

  // Take input unless a held result would be overwritten
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Parse one byte
  always_comb begin
    logic [3:0] pre, size, eb, e, tpos;
    logic [8:0] endpos;
    logic [31:0] v;
    logic [7:0]  q;
    parse_phase_next     = parse_phase;
    frame_length_next    = frame_length;
    byte_position_next   = byte_position;
    frame_is_info_next   = frame_is_info;
    object_type_next     = object_type;
    object_count_next    = object_count;
    sequence_mode_next   = sequence_mode;
    asdu_address_next    = asdu_address;
    running_address_next = running_address;
    object_index_next    = object_index;
    element_byte_next    = element_byte;
    value_accum_next     = value_accum;
    quality_hold_next    = quality_hold;
    time_accum_next      = time_accum;
    send_seq_next_next   = send_seq_next;
    emit = 1'b0;
    res  = '0;
    pre  = sequence_mode ? 4'd0 : 4'd3;
    size = pre + ly.stride;
    eb   = element_byte;
    e    = eb - pre;
    tpos = e - ly.toff;
    endpos = {1'b0, byte_position} + {5'd0, size} + 9'd1;
    v = '0;
    q = '0;
    case (parse_phase)
      iap_pkg::PH_LEN: begin
        frame_length_next  = rx_byte;
        byte_position_next = '0;
        frame_is_info_next = 1'b0;
        object_count_next  = '0;
        object_index_next  = '0;
        element_byte_next  = '0;
        parse_phase_next   = (rx_byte == 8'd0) ? iap_pkg::PH_HUNT : iap_pkg::PH_BODY;
      end
      iap_pkg::PH_BODY: begin
        if (byte_position == 8'd0) begin
          frame_is_info_next = (frame_length >= 8'd10) && !rx_byte[0];
          value_accum_next   = {24'd0, rx_byte};
        end else if (byte_position == 8'd1) begin
          if (frame_is_info)
            send_seq_next_next = {rx_byte[7:0], value_accum[7:1]} + 15'd1;
        end else if (byte_position == 8'd4) begin
          object_type_next = rx_byte;
        end else if (byte_position == 8'd5) begin
          object_count_next  = rx_byte[6:0];
          sequence_mode_next = rx_byte[7];
        end else if (byte_position == 8'd8) begin
          asdu_address_next = {8'd0, rx_byte};
        end else if (byte_position == 8'd9) begin
          asdu_address_next = {rx_byte, asdu_address[7:0]};
        end else if (byte_position >= 8'd10 && frame_is_info) begin
          if (sequence_mode && byte_position <= 8'd12) begin
            case (byte_position[1:0])
              2'd2:    running_address_next = {16'd0, rx_byte};
              2'd3:    running_address_next[15:8] = rx_byte;
              default: running_address_next[23:16] = rx_byte;
            endcase
          end else if (ly.stride != 4'd0 && object_index < object_count) begin
            // Accumulate one object byte
            if (eb == 4'd0) begin
              value_accum_next  = '0;
              quality_hold_next = '0;
              time_accum_next   = '0;
              if (!sequence_mode) running_address_next = '0;
            end
            if (eb < pre) begin
              running_address_next[8*eb[1:0] +: 8] = rx_byte;
            end else begin
              if ({1'b0, e} < {2'b0, ly.vlen}) value_accum_next[8*e[1:0] +: 8] = rx_byte;
              if (e == ly.qoff) quality_hold_next = rx_byte;
              if (ly.toff != iap_pkg::NONE_OFF && e >= ly.toff && tpos < 4'd7)
                time_accum_next[8*tpos[2:0] +: 8] = rx_byte;
            end
            if (eb + 4'd1 < size) begin
              element_byte_next = eb + 4'd1;
            end else begin
              // Finish object and form result
              emit = 1'b1;
              v = value_accum_next;
              q = quality_hold_next;
              if (object_type == 8'd1 || object_type == 8'd30) begin
                v = v & 32'h1; q = q & 8'hFE;
              end else if (object_type == 8'd3 || object_type == 8'd31) begin
                v = v & 32'h3; q = q & 8'hFC;
              end else if (object_type == 8'd11 || object_type == 8'd35) begin
                v = {{16{v[15]}}, v[15:0]};
              end
              if (object_type == 8'd21) q = '0;
              res.type_id        = object_type;
              res.object_address = running_address_next;
              res.common_address = asdu_address;
              res.value_bits     = v;
              res.quality_bits   = q;
              res.has_time       = ly.toff != iap_pkg::NONE_OFF;
              res.time_raw       = res.has_time ? time_accum_next : '0;
              res.next_rx_seq    = send_seq_next;
              res.last_of_frame  = (object_index + 7'd1 >= object_count)
                                   || (endpos > {1'b0, frame_length});
              element_byte_next  = '0;
              object_index_next  = object_index + 7'd1;
              if (sequence_mode) running_address_next = running_address_next + 24'd1;
            end
          end
        end
        if ({1'b0, byte_position} + 9'd1 >= {1'b0, frame_length}) begin
          parse_phase_next   = iap_pkg::PH_HUNT;
          byte_position_next = '0;
        end else begin
          byte_position_next = byte_position + 8'd1;
        end
      end
      default: begin
        parse_phase_next = (rx_byte == iap_pkg::START_BYTE) ? iap_pkg::PH_LEN
                                                            : iap_pkg::PH_HUNT;
      end
    endcase
  end

  // Update parse state on each byte transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase     <= iap_pkg::PH_HUNT;
      frame_length    <= '0;
      byte_position   <= '0;
      frame_is_info   <= 1'b0;
      object_type     <= '0;
      object_count    <= '0;
      sequence_mode   <= 1'b0;
      asdu_address    <= '0;
      running_address <= '0;
      object_index    <= '0;
      element_byte    <= '0;
      value_accum     <= '0;
      quality_hold    <= '0;
      time_accum      <= '0;
      send_seq_next   <= '0;
    end else if (accept) begin
      parse_phase     <= parse_phase_next;
      frame_length    <= frame_length_next;
      byte_position   <= byte_position_next;
      frame_is_info   <= frame_is_info_next;
      object_type     <= object_type_next;
      object_count    <= object_count_next;
      sequence_mode   <= sequence_mode_next;
      asdu_address    <= asdu_address_next;
      running_address <= running_address_next;
      object_index    <= object_index_next;
      element_byte    <= element_byte_next;
      value_accum     <= value_accum_next;
      quality_hold    <= quality_hold_next;
      time_accum      <= time_accum_next;
      send_seq_next   <= send_seq_next_next;
    end
  end

  // Hold the result until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) res_q <= res;
  end

  assign type_id        = res_q.type_id;
  assign object_address = res_q.object_address;
  assign common_address = res_q.common_address;
  assign value_bits     = res_q.value_bits;
  assign quality_bits   = res_q.quality_bits;
  assign time_raw       = res_q.time_raw;
  assign has_time       = res_q.has_time;
  assign next_rx_seq    = res_q.next_rx_seq;
  assign last_of_frame  = res_q.last_of_frame;

  // A stalled result must not be replaced
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(res_q))
    else $error("result changed while stalled");

  // Results only come from body bytes
  a_emit_body: assert property (@(posedge clk) disable iff (rst)
    accept && emit |-> parse_phase == iap_pkg::PH_BODY)
    else $error("result outside frame body");

  // Element counter stays inside the largest object
  a_elem: assert property (@(posedge clk) disable iff (rst)
    element_byte < 4'd15)
    else $error("element counter overflow");

endmodule

>>> tb/tb_iec104_apdu_object_parser.sv
// Self-checking testbench for iec104_apdu_object_parser: random byte streams in, objects out.
// Holds its own model of the frame parser and scoreboards each result field by field.
// Depends on rtl/iap_pkg.sv and rtl/iec104_apdu_object_parser.sv.
module tb_iec104_apdu_object_parser;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  type_id;
  logic [23:0] object_address;
  logic [15:0] common_address;
  logic [31:0] value_bits;
  logic [7:0]  quality_bits;
  logic [55:0] time_raw;
  logic        has_time;
  logic [14:0] next_rx_seq;
  logic        last_of_frame;

  iec104_apdu_object_parser uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Pending link bytes and expected objects
  logic [7:0]       link_bytes[$];
  iap_pkg::result_t object_q[$];
  int         fail_count = 0;
  bit         no_idle = 1'b0;
  int         gap_cnt = 0;
  int         stall_cnt = 0;
  int         quiet_cycles = 0;

  // Parser model state
  iap_pkg::phase_t m_phase = iap_pkg::PH_HUNT;
  int          m_len = 0;
  int          m_pos = 0;
  bit          m_info = 1'b0;
  logic [7:0]  m_type = 8'h00;
  int          m_count = 0;
  bit          m_sq = 1'b0;
  logic [15:0] m_ca = 16'h0000;
  logic [23:0] m_ioa = 24'h0;
  int          m_idx = 0;
  int          m_elem = 0;
  logic [31:0] m_val = 32'h0;
  logic [7:0]  m_qual = 8'h00;
  logic [55:0] m_time = 56'h0;
  logic [14:0] m_nr = 15'h0;

  // Element layout without the IOA: stride, value length, quality and time offsets
  task automatic element_shape(input logic [7:0] t, output int s, output int v,
                               output int q, output int tm);
    s = 0; v = 0; q = 15; tm = 15;
    case (t)
      8'd1, 8'd3: begin s = 1; v = 1; q = 0; end
      8'd5: begin s = 2; v = 1; q = 1; end
      8'd7, 8'd13, 8'd15, 8'd20: begin s = 5; v = 4; q = 4; end
      8'd9, 8'd11: begin s = 3; v = 2; q = 2; end
      8'd21: begin s = 2; v = 2; end
      8'd30, 8'd31: begin s = 8; v = 1; q = 0; tm = 1; end
      8'd32: begin s = 9; v = 1; q = 1; tm = 2; end
      8'd33, 8'd36, 8'd37: begin s = 12; v = 4; q = 4; tm = 5; end
      8'd34, 8'd35: begin s = 10; v = 2; q = 2; tm = 3; end
      8'd38, 8'd39, 8'd40: begin s = 11; v = 1; q = 1; tm = 4; end
      default: ;
    endcase
  endtask

  // Fold one byte of an information object; queue the object when complete
  task automatic object_byte(input logic [7:0] b, input int p);
    int s, v, q, tm, pre, sz, e;
    iap_pkg::result_t r;
    element_shape(m_type, s, v, q, tm);
    pre = m_sq ? 0 : 3;
    if (s == 0 || m_idx >= m_count) return;
    sz = pre + s;
    if (m_elem == 0) begin
      m_val = '0; m_qual = '0; m_time = '0;
      if (!m_sq) m_ioa = '0;
    end
    if (m_elem < pre) m_ioa = m_ioa | (24'(b) << (8 * m_elem));
    else begin
      e = m_elem - pre;
      if (e < v) m_val = m_val | (32'(b) << (8 * e));
      if (e == q) m_qual = b;
      if (tm != 15 && e >= tm && e < tm + 7) m_time = m_time | (56'(b) << (8 * (e - tm)));
    end
    if (m_elem + 1 < sz) begin
      m_elem = m_elem + 1;
      return;
    end
    r.type_id = m_type;
    r.object_address = m_ioa;
    r.common_address = m_ca;
    r.value_bits = m_val;
    r.quality_bits = m_qual;
    if (m_type == 8'd1 || m_type == 8'd30) begin
      r.value_bits = m_val & 32'h1; r.quality_bits = m_qual & 8'hFE;
    end else if (m_type == 8'd3 || m_type == 8'd31) begin
      r.value_bits = m_val & 32'h3; r.quality_bits = m_qual & 8'hFC;
    end else if (m_type == 8'd11 || m_type == 8'd35) begin
      r.value_bits = {{16{m_val[15]}}, m_val[15:0]};
    end
    if (m_type == 8'd21) r.quality_bits = 8'h00;
    r.time_raw = (tm != 15) ? m_time : 56'h0;
    r.has_time = (tm != 15);
    r.next_rx_seq = m_nr;
    r.last_of_frame = (m_idx + 1 >= m_count) || (p + sz + 1 > m_len);
    object_q.push_back(r);
    m_elem = 0;
    m_idx = (m_idx + 1) & 8'h7F;
    if (m_sq) m_ioa = m_ioa + 24'd1;
  endtask

  // Advance the parser model by one transferred byte
  task automatic absorb_byte(input logic [7:0] b);
    int p;
    if (m_phase == iap_pkg::PH_LEN) begin
      m_len = b; m_pos = 0; m_info = 1'b0; m_count = 0; m_idx = 0; m_elem = 0;
      m_phase = (b == 8'h00) ? iap_pkg::PH_HUNT : iap_pkg::PH_BODY;
    end else if (m_phase != iap_pkg::PH_BODY) begin
      m_phase = (b == iap_pkg::START_BYTE) ? iap_pkg::PH_LEN : iap_pkg::PH_HUNT;
    end else begin
      p = m_pos;
      if (p == 0) begin
        m_info = (m_len >= 10) && !b[0];
        m_val = 32'(b);
      end else if (p == 1) begin
        if (m_info) m_nr = 15'(m_val[7:1]) + {b, 7'b0} + 15'd1;
      end else if (p == 4) m_type = b;
      else if (p == 5) begin
        m_count = b[6:0]; m_sq = b[7];
      end else if (p == 8) m_ca = {8'h00, b};
      else if (p == 9) m_ca[15:8] = b;
      else if (p >= 10 && m_info) begin
        if (m_sq && p <= 12) begin
          if (p == 10) m_ioa = '0;
          m_ioa = m_ioa | (24'(b) << (8 * (p - 10)));
        end else object_byte(b, p);
      end
      if (p + 1 >= m_len) begin
        m_phase = iap_pkg::PH_HUNT; m_pos = 0;
      end else m_pos = p + 1;
    end
  endtask

  // Queue one frame: header with given control/type/qualifier, random fill elsewhere
  task automatic add_frame(input logic [7:0] c0, input logic [7:0] t,
                           input logic [7:0] vsq, input int info_len);
    int n;
    n = info_len;
    link_bytes.push_back(iap_pkg::START_BYTE);
    link_bytes.push_back(8'(10 + n));
    link_bytes.push_back(c0);
    link_bytes.push_back(8'($urandom));
    link_bytes.push_back(8'($urandom));
    link_bytes.push_back(8'($urandom));
    link_bytes.push_back(t);
    link_bytes.push_back(vsq);
    repeat (4) link_bytes.push_back(8'($urandom));
    repeat (n) link_bytes.push_back(8'($urandom));
  endtask

  // Queue a random frame: mostly well formed, some noise and broken frames
  task automatic add_random;
    logic [7:0] t;
    int r, s, v, q, tm, n, sq, len;
    logic [7:0] supported[19] = '{1, 3, 5, 7, 9, 11, 13, 15, 20, 21,
                                  30, 31, 32, 33, 34, 35, 36, 37, 38};
    r = $urandom_range(0, 99);
    if (r < 8) begin
      repeat ($urandom_range(1, 4)) link_bytes.push_back(8'($urandom));
    end else if (r < 14) begin
      link_bytes.push_back(iap_pkg::START_BYTE);
      link_bytes.push_back(8'd4);
      link_bytes.push_back(8'($urandom) | 8'h01);
      repeat (3) link_bytes.push_back(8'($urandom));
    end else if (r < 18) begin
      len = $urandom_range(0, 9);
      link_bytes.push_back(iap_pkg::START_BYTE);
      link_bytes.push_back(8'(len));
      repeat (len) link_bytes.push_back(8'($urandom));
    end else begin
      if ($urandom_range(0, 9) == 0) t = 8'($urandom);
      else if ($urandom_range(0, 19) == 0) t = 8'd40;
      else t = supported[$urandom_range(0, 18)];
      element_shape(t, s, v, q, tm);
      if (s == 0) s = 4;
      n = $urandom_range(1, 6);
      sq = $urandom_range(0, 1);
      len = sq ? 3 + n * s : n * (3 + s);
      if ($urandom_range(0, 4) == 0) len = len + $urandom_range(0, 6) - 3;
      if (len < 0) len = 0;
      if ($urandom_range(0, 15) == 0) n = $urandom_range(0, 127);
      add_frame(8'($urandom) & 8'hFE, t, {sq[0], n[6:0]}, len);
    end
  endtask

  // Compare one field, report on mismatch
  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $realtime, name, want, got);
      fail_count++;
    end
  endtask

  // Drive bytes from the pending queue, with random gaps; model each transfer
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) absorb_byte(rx_byte);
      if (in_valid && !in_ready) begin
        // hold the byte until it transfers
      end else if (!no_idle && gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
        in_valid <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        gap_cnt <= $urandom_range(0, 7);
        in_valid <= 1'b0;
      end else if (link_bytes.size() > 0) begin
        in_valid <= 1'b1;
        rx_byte <= link_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result side in random bursts
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_cnt <= $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Check each result transfer against the oldest expected object
  always @(posedge clk) begin
    iap_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      if (object_q.size() == 0) begin
        $display("%0t: unexpected object expected none actual type %h ioa %h",
                 $realtime, type_id, object_address);
        fail_count++;
      end else begin
        want = object_q.pop_front();
        check_field("type_id", want.type_id, type_id);
        check_field("object_address", want.object_address, object_address);
        check_field("common_address", want.common_address, common_address);
        check_field("value_bits", want.value_bits, value_bits);
        check_field("quality_bits", want.quality_bits, quality_bits);
        check_field("time_raw", want.time_raw, time_raw);
        check_field("has_time", want.has_time, has_time);
        check_field("next_rx_seq", want.next_rx_seq, next_rx_seq);
        check_field("last_of_frame", want.last_of_frame, last_of_frame);
      end
    end
  end

  // Watchdog: end the run when nothing transfers for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 2000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Wait until all bytes have transferred and all objects have come out
  task automatic drain;
    while (link_bytes.size() > 0 || in_valid || object_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: stray bytes, empty frame, S-format, short frame
    link_bytes.push_back(8'h00);
    link_bytes.push_back(8'hFF);
    link_bytes.push_back(8'h16);
    link_bytes.push_back(iap_pkg::START_BYTE);
    link_bytes.push_back(8'h00);
    link_bytes.push_back(iap_pkg::START_BYTE);
    link_bytes.push_back(8'h04);
    link_bytes.push_back(8'h01);
    link_bytes.push_back(8'h00);
    link_bytes.push_back(8'hFE);
    link_bytes.push_back(8'hFF);
    link_bytes.push_back(iap_pkg::START_BYTE);
    link_bytes.push_back(8'h06);
    repeat (6) link_bytes.push_back(8'hFF);
    // count zero, unknown type, single points, signed SQ=1 run, overrun, short SQ=1
    add_frame(8'hFE, 8'd13, 8'h00, 5);
    add_frame(8'h00, 8'd2, 8'h01, 4);
    add_frame(8'hFE, 8'd1, 8'h02, 8);
    add_frame(8'h02, 8'd35, 8'h82, 23);
    add_frame(8'h00, 8'd36, 8'h01, 8);
    add_frame(8'h00, 8'd30, 8'h81, 2);
    add_frame(8'hFE, 8'd40, 8'h7F, 245);
    drain();

    // Random stream, then a full pause until every object has come out
    while (link_bytes.size() < 100) add_random();
    drain();
    while (link_bytes.size() < 70) add_random();
    drain();

    // Final stretch with both sides running flat out
    no_idle = 1'b1;
    while (link_bytes.size() < 40) add_random();
    drain();

    repeat (20) @(posedge clk);
    if (fail_count == 0 && object_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/iap_pkg.sv
rtl/iap_layout.sv
rtl/iec104_apdu_object_parser.sv
tb/tb_iec104_apdu_object_parser.sv
